>>> hw/rtl/tvi_pkg.sv
// Shared constants and types for the three-voltmeter impedance meter.
`default_nettype none
package tvi_pkg;
   localparam int RES_W     = 20;   // reference resistance register width
   localparam int THR_W     = 12;   // threshold register width
   localparam int CSR_W     = 20;   // widest register
   localparam int CSR_IDX_W = 1;
   localparam int MAG_OUT_W = 32;
   localparam int COS_OUT_W = 16;
   localparam int RES_OUT_W = 33;

   localparam logic [CSR_IDX_W-1:0] CSR_REFERENCE_RESISTANCE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_SIGNAL_MV        = 1'd1;

   localparam logic [MAG_OUT_W-1:0] MAG_MAX = 32'hFFFF_FFFF;

   // classification that rides along with each reading set
   typedef struct packed {
      logic no_signal;
      logic clamp;     // |numerator| >= denominator: cosine saturates
      logic cneg;      // numerator of the cosine is negative
   } tag_type;
endpackage
`default_nettype wire

>>> hw/rtl/tvi_front.sv
// Front end: takes readings, flags no signal, forms products and cosine numerator.
`default_nettype none
module tvi_front #(
   parameter int VOLT_BITS = 12
) (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            accept,
   input  wire                            stall,
   input  wire [VOLT_BITS-1:0]            total_mv,
   input  wire [VOLT_BITS-1:0]            reference_mv,
   input  wire [VOLT_BITS-1:0]            unknown_mv,
   input  wire [tvi_pkg::RES_W-1:0]       reference_resistance,
   input  wire [tvi_pkg::THR_W-1:0]       min_signal_mv,
   output logic                           push,
   output tvi_pkg::tag_type               tag,
   output logic [2*VOLT_BITS:0]           cmag,
   output logic [2*VOLT_BITS:0]           den,
   output logic [tvi_pkg::RES_W+VOLT_BITS-1:0] prod,
   output logic [VOLT_BITS-1:0]           un
);
   localparam int CW    = (VOLT_BITS > tvi_pkg::THR_W) ? VOLT_BITS : tvi_pkg::THR_W;
   localparam int SQ_W  = 2*VOLT_BITS;
   localparam int NM_W  = 2*VOLT_BITS + 1;
   localparam int MAG_W = tvi_pkg::RES_W + VOLT_BITS;

   logic               valid_ff, valid_in;
   logic               nosig_ff, nosig_in;
   logic [SQ_W-1:0]    pos_ff, pos_in;
   logic [NM_W-1:0]    neg_ff, neg_in;
   logic [NM_W-1:0]    den_ff, den_in;
   logic [MAG_W-1:0]   prod_ff, prod_in;
   logic [VOLT_BITS-1:0] un_ff, un_in;
   logic [NM_W-1:0]    pos_ext;
   logic [SQ_W-1:0]    un_sq, ux_sq;

   always_comb begin
      valid_in = valid_ff;
      nosig_in = nosig_ff;
      pos_in   = pos_ff;
      neg_in   = neg_ff;
      den_in   = den_ff;
      prod_in  = prod_ff;
      un_in    = un_ff;
      un_sq    = reference_mv * reference_mv;
      ux_sq    = unknown_mv * unknown_mv;
      if (!stall) begin
         valid_in = accept;
         nosig_in = (CW'(total_mv) < CW'(min_signal_mv)) ||
                    (CW'(reference_mv) < CW'(min_signal_mv)) ||
                    (CW'(unknown_mv) < CW'(min_signal_mv)) ||
                    (reference_mv == '0) || (unknown_mv == '0);
         pos_in   = total_mv * total_mv;
         neg_in   = NM_W'(un_sq) + NM_W'(ux_sq);
         den_in   = {SQ_W'(reference_mv * unknown_mv), 1'b0};
         prod_in  = reference_resistance * MAG_W'(unknown_mv);
         un_in    = reference_mv;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      nosig_ff <= nosig_in;
      pos_ff   <= pos_in;
      neg_ff   <= neg_in;
      den_ff   <= den_in;
      prod_ff  <= prod_in;
      un_ff    <= un_in;
   end

   // sign-magnitude numerator of the law of cosines
   always_comb begin
      pos_ext       = NM_W'(pos_ff);
      tag.no_signal = nosig_ff;
      tag.cneg      = pos_ext < neg_ff;
      cmag          = tag.cneg ? (neg_ff - pos_ext) : (pos_ext - neg_ff);
      tag.clamp     = cmag >= den_ff;
      push          = valid_ff && !stall;
   end

   assign den  = den_ff;
   assign prod = prod_ff;
   assign un   = un_ff;
endmodule
`default_nettype wire

>>> hw/rtl/tvi_queue.sv
// Two-entry queue between front and back end.
`default_nettype none
module tvi_queue #(
   parameter int DATA_W = 8
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               push,
   input  wire [DATA_W-1:0]  push_data,
   output logic              full,
   output logic              pop,
   output logic [DATA_W-1:0] pop_data
);
   logic [DATA_W-1:0] entry_ff [2];
   logic              wr_ptr_ff, rd_ptr_ff;
   logic [1:0]        count_ff, count_in;

   // back end never stalls, so pop whenever something is held
   assign pop      = count_ff != 2'd0;
   assign full     = count_ff == 2'd2;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) count_in = count_ff + 2'd1;
      else if (!push && pop) count_in = count_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         count_ff <= count_in;
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (pop) rd_ptr_ff <= !rd_ptr_ff;
      end
      if (push) entry_ff[wr_ptr_ff] <= push_data;
   end
endmodule
`default_nettype wire

>>> hw/rtl/tvi_div.sv
// Pipelined restoring divider, one quotient bit per stage, with padding stages.
`default_nettype none
module tvi_div #(
   parameter int NUM_W = 32,
   parameter int DEN_W = 12,
   parameter int PAD   = 0,
   parameter int TAG_W = 1
) (
   input  wire              clock,
   input  wire              reset,
   input  wire              in_valid,
   input  wire [DEN_W-1:0]  in_rem,
   input  wire [NUM_W-1:0]  in_num,
   input  wire [DEN_W-1:0]  in_den,
   input  wire [TAG_W-1:0]  in_tag,
   output logic             out_valid,
   output logic [NUM_W-1:0] out_quo,
   output logic [TAG_W-1:0] out_tag
);
   localparam int L = NUM_W + PAD;

   logic             v_ff   [L+1];
   logic [DEN_W-1:0] rem_ff [L+1];
   logic [NUM_W-1:0] num_ff [L+1];
   logic [NUM_W-1:0] quo_ff [L+1];
   logic [DEN_W-1:0] den_ff [L+1];
   logic [TAG_W-1:0] tag_ff [L+1];

   always_ff @(posedge clock) begin
      if (reset) v_ff[0] <= 1'b0;
      else v_ff[0] <= in_valid;
      rem_ff[0] <= in_rem;
      num_ff[0] <= in_num;
      quo_ff[0] <= '0;
      den_ff[0] <= in_den;
      tag_ff[0] <= in_tag;
   end

   for (genvar i = 0; i < L; i++) begin : g_stage
      logic [DEN_W:0]   trial, diff;
      logic             ge;
      logic [DEN_W-1:0] rem_in;
      logic [NUM_W-1:0] num_in, quo_in;

      always_comb begin
         trial  = {rem_ff[i], num_ff[i][NUM_W-1]};
         diff   = trial - {1'b0, den_ff[i]};
         ge     = trial >= {1'b0, den_ff[i]};
         rem_in = rem_ff[i];
         num_in = num_ff[i];
         quo_in = quo_ff[i];
         if (i < NUM_W) begin
            rem_in = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            num_in = num_ff[i] << 1;
            quo_in = {quo_ff[i][NUM_W-2:0], ge};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) v_ff[i+1] <= 1'b0;
         else v_ff[i+1] <= v_ff[i];
         rem_ff[i+1] <= rem_in;
         num_ff[i+1] <= num_in;
         quo_ff[i+1] <= quo_in;
         den_ff[i+1] <= den_ff[i];
         tag_ff[i+1] <= tag_ff[i];
      end
   end

   assign out_valid = v_ff[L];
   assign out_quo   = quo_ff[L];
   assign out_tag   = tag_ff[L];
endmodule
`default_nettype wire

>>> hw/rtl/tvi_back.sv
// Back end: magnitude and cosine dividers, saturation, resistive product, result register.
`default_nettype none
module tvi_back #(
   parameter int VOLT_BITS     = 12,
   parameter int COS_FRAC_BITS = 15
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  in_valid,
   input  wire tvi_pkg::tag_type                in_tag,
   input  wire [2*VOLT_BITS:0]                  in_cmag,
   input  wire [2*VOLT_BITS:0]                  in_den,
   input  wire [tvi_pkg::RES_W+VOLT_BITS-1:0]   in_prod,
   input  wire [VOLT_BITS-1:0]                  in_un,
   output logic                                 rsp_strobe,
   output logic                                 rsp_no_signal,
   output logic [tvi_pkg::MAG_OUT_W-1:0]        rsp_impedance_magnitude,
   output logic signed [tvi_pkg::COS_OUT_W-1:0] rsp_phase_cosine,
   output logic signed [tvi_pkg::RES_OUT_W-1:0] rsp_resistive_part
);
   localparam int F      = COS_FRAC_BITS;
   localparam int MAG_W  = tvi_pkg::RES_W + VOLT_BITS;
   localparam int NM_W   = 2*VOLT_BITS + 1;
   localparam int L      = (MAG_W > F) ? MAG_W : F;
   localparam int EXT_W  = (MAG_W > 33) ? MAG_W : 33;
   localparam int COSX_W = (F + 2 > 16) ? F + 2 : 16;
   localparam int P_W    = tvi_pkg::MAG_OUT_W + F + 1;
   localparam int TW     = $bits(tvi_pkg::tag_type);

   logic             mv, cv;
   logic [MAG_W-1:0] mq;
   logic [F-1:0]     cq;
   logic [TW-1:0]    mtag_bits;
   logic             ctag;
   tvi_pkg::tag_type mtag;

   tvi_div #(.NUM_W(MAG_W), .DEN_W(VOLT_BITS), .PAD(L - MAG_W), .TAG_W(TW)) u_mag_div (
      .clock(clock), .reset(reset), .in_valid(in_valid), .in_rem('0),
      .in_num(in_prod), .in_den(in_un), .in_tag(in_tag),
      .out_valid(mv), .out_quo(mq), .out_tag(mtag_bits)
   );

   tvi_div #(.NUM_W(F), .DEN_W(NM_W), .PAD(L - F), .TAG_W(1)) u_cos_div (
      .clock(clock), .reset(reset), .in_valid(in_valid), .in_rem(in_cmag),
      .in_num('0), .in_den(in_den), .in_tag(in_tag.cneg),
      .out_valid(cv), .out_quo(cq), .out_tag(ctag)
   );

   assign mtag = tvi_pkg::tag_type'(mtag_bits);

   // stage A: saturate magnitude, resolve cosine clamp
   logic                          a_v_ff;
   tvi_pkg::tag_type              a_tag_ff;
   logic [tvi_pkg::MAG_OUT_W-1:0] a_mag_ff, a_mag_in;
   logic [F:0]                    a_cos_ff, a_cos_in;
   logic [EXT_W-1:0]              mq_ext;

   always_comb begin
      mq_ext   = EXT_W'(mq);
      a_mag_in = (mq_ext > EXT_W'(tvi_pkg::MAG_MAX)) ? tvi_pkg::MAG_MAX
                                                     : mq_ext[tvi_pkg::MAG_OUT_W-1:0];
      if (mtag.clamp) a_cos_in = ctag ? {1'b1, F'(0)} : {1'b0, {F{1'b1}}};
      else a_cos_in = {1'b0, cq};
   end

   // stage B: resistive product
   logic                          b_v_ff;
   tvi_pkg::tag_type              b_tag_ff;
   logic [tvi_pkg::MAG_OUT_W-1:0] b_mag_ff;
   logic [F:0]                    b_cos_ff;
   logic [P_W-1:0]                b_prod_ff;

   // result formatting
   logic [COSX_W-1:0]             cos_ext;
   logic [tvi_pkg::RES_OUT_W-1:0] rmag;

   always_comb begin
      cos_ext = COSX_W'(b_cos_ff);
      if (b_tag_ff.cneg) cos_ext = -cos_ext;
      rmag = b_prod_ff[F+tvi_pkg::MAG_OUT_W:F];
      if (b_tag_ff.cneg) rmag = -rmag;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff     <= 1'b0;
         b_v_ff     <= 1'b0;
         rsp_strobe <= 1'b0;
      end else begin
         a_v_ff     <= mv;
         b_v_ff     <= a_v_ff;
         rsp_strobe <= b_v_ff;
      end
      a_tag_ff  <= mtag;
      a_mag_ff  <= a_mag_in;
      a_cos_ff  <= a_cos_in;
      b_tag_ff  <= a_tag_ff;
      b_mag_ff  <= a_mag_ff;
      b_cos_ff  <= a_cos_ff;
      b_prod_ff <= a_mag_ff * P_W'(a_cos_ff);
      rsp_no_signal <= b_tag_ff.no_signal;
      if (b_tag_ff.no_signal) begin
         rsp_impedance_magnitude <= '0;
         rsp_phase_cosine        <= '0;
         rsp_resistive_part      <= '0;
      end else begin
         rsp_impedance_magnitude <= b_mag_ff;
         rsp_phase_cosine        <= cos_ext[tvi_pkg::COS_OUT_W-1:0];
         rsp_resistive_part      <= rmag;
      end
   end

   // both dividers must stay in lockstep
   a_div_lockstep: assert property (@(posedge clock) disable iff (reset) mv == cv)
      else $error("divider pipelines out of step");
   a_cneg_copy: assert property (@(posedge clock) disable iff (reset)
      mv |-> (ctag == mtag.cneg))
      else $error("cosine sign lost between dividers");
   a_clamp_bound: assert property (@(posedge clock) disable iff (reset)
      a_v_ff |-> (a_cos_ff <= {1'b1, F'(0)}))
      else $error("cosine magnitude above one");
endmodule
`default_nettype wire

>>> hw/rtl/three_voltmeter_impedance.sv
// Top level of the three-voltmeter impedance meter.
// Each reading set (total, reference, unknown, in millivolts) is transferred at a clock edge
// with start high and busy low; one may follow every cycle. Its result appears on the rsp_
// ports for exactly one cycle, marked by rsp_strobe. The receiver cannot stall. Each set
// passes through the front register, the queue, the bit-per-stage magnitude divider
// (20 + VOLT_BITS stages, padded to COS_FRAC_BITS when wider) and finishing registers.
// When any reading is below min_signal_mv, or the reference or unknown reading is zero,
// rsp_no_signal is set and the other fields are zero. Otherwise the magnitude is
// R*unknown/reference (1/16 ohm, truncated, saturating), the cosine comes from the law of
// cosines in Q1.COS_FRAC_BITS clamped to [-1, 1), and the resistive part is
// magnitude*cosine truncated toward zero. The user must write registers through
// csr_we/csr_index/csr_wdata only while the block is idle; the block does not enforce it.
`default_nettype none
module three_voltmeter_impedance #(
   parameter int VOLT_BITS     = 12,
   parameter int COS_FRAC_BITS = 15
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  start,
   output logic                                 busy,
   input  wire [VOLT_BITS-1:0]                  req_total_mv,
   input  wire [VOLT_BITS-1:0]                  req_reference_mv,
   input  wire [VOLT_BITS-1:0]                  req_unknown_mv,
   output logic                                 rsp_strobe,
   output logic                                 rsp_no_signal,
   output logic [tvi_pkg::MAG_OUT_W-1:0]        rsp_impedance_magnitude,
   output logic signed [tvi_pkg::COS_OUT_W-1:0] rsp_phase_cosine,
   output logic signed [tvi_pkg::RES_OUT_W-1:0] rsp_resistive_part,
   input  wire                                  csr_we,
   input  wire [tvi_pkg::CSR_IDX_W-1:0]         csr_index,
   input  wire [tvi_pkg::CSR_W-1:0]             csr_wdata
);
   localparam int MAG_W   = tvi_pkg::RES_W + VOLT_BITS;
   localparam int NM_W    = 2*VOLT_BITS + 1;
   localparam int L       = (MAG_W > COS_FRAC_BITS) ? MAG_W : COS_FRAC_BITS;
   localparam int LATENCY = 6 + L;
   localparam int TW      = $bits(tvi_pkg::tag_type);
   localparam int Q_W     = TW + 2*NM_W + MAG_W + VOLT_BITS;

   // configuration registers
   logic [tvi_pkg::RES_W-1:0] ref_res_ff;
   logic [tvi_pkg::THR_W-1:0] min_sig_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_res_ff <= tvi_pkg::RES_W'(1600);
         min_sig_ff <= tvi_pkg::THR_W'(10);
      end else if (csr_we) begin
         case (csr_index)
            tvi_pkg::CSR_REFERENCE_RESISTANCE: ref_res_ff <= csr_wdata[tvi_pkg::RES_W-1:0];
            tvi_pkg::CSR_MIN_SIGNAL_MV:        min_sig_ff <= csr_wdata[tvi_pkg::THR_W-1:0];
            default: ;
         endcase
      end
   end

   // front end: classify, square, form products
   logic                 f_push, q_full, q_pop;
   tvi_pkg::tag_type     f_tag, b_tag;
   logic [NM_W-1:0]      f_cmag, f_den, b_cmag, b_den;
   logic [MAG_W-1:0]     f_prod, b_prod;
   logic [VOLT_BITS-1:0] f_un, b_un;
   logic [Q_W-1:0]       q_out;

   // queue full holds off new transfers; the back end drains one entry per cycle
   assign busy = q_full;

   tvi_front #(.VOLT_BITS(VOLT_BITS)) u_front (
      .clock(clock), .reset(reset), .accept(start && !busy), .stall(q_full),
      .total_mv(req_total_mv), .reference_mv(req_reference_mv),
      .unknown_mv(req_unknown_mv), .reference_resistance(ref_res_ff),
      .min_signal_mv(min_sig_ff), .push(f_push), .tag(f_tag), .cmag(f_cmag),
      .den(f_den), .prod(f_prod), .un(f_un)
   );

   tvi_queue #(.DATA_W(Q_W)) u_queue (
      .clock(clock), .reset(reset), .push(f_push),
      .push_data({f_tag, f_cmag, f_den, f_prod, f_un}),
      .full(q_full), .pop(q_pop), .pop_data(q_out)
   );

   assign {b_tag, b_cmag, b_den, b_prod, b_un} = q_out;

   // back end: dividers and result formatting
   tvi_back #(.VOLT_BITS(VOLT_BITS), .COS_FRAC_BITS(COS_FRAC_BITS)) u_back (
      .clock(clock), .reset(reset), .in_valid(q_pop), .in_tag(b_tag),
      .in_cmag(b_cmag), .in_den(b_den), .in_prod(b_prod), .in_un(b_un),
      .rsp_strobe(rsp_strobe), .rsp_no_signal(rsp_no_signal),
      .rsp_impedance_magnitude(rsp_impedance_magnitude),
      .rsp_phase_cosine(rsp_phase_cosine), .rsp_resistive_part(rsp_resistive_part)
   );

   // every transfer is answered by a result strobe
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_strobe)
      else $error("result missing at expected latency");
   // the queue drains every cycle so it never fills
   a_never_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("queue backed up");
   a_no_signal_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_no_signal) |-> (rsp_impedance_magnitude == '0 &&
      rsp_phase_cosine == '0 && rsp_resistive_part == '0))
      else $error("no-signal result carries data");
endmodule
`default_nettype wire

>>> bench/three_voltmeter_impedance_tb.sv
// Testbench for the three-voltmeter impedance meter: directed table, register extremes and random readings.
`timescale 1ns / 1ps
module three_voltmeter_impedance_tb;

   localparam int LATENCY   = 38;
   localparam int CYCLE_MAX = 400000;

   // one expected (or observed) reading result
   typedef struct packed {
      logic                                 no_signal;
      logic [tvi_pkg::MAG_OUT_W-1:0]        magnitude;
      logic signed [tvi_pkg::COS_OUT_W-1:0] cosine;
      logic signed [tvi_pkg::RES_OUT_W-1:0] resistive;
   } meter_result_type;

   // directed row: readings, plus an optional typed-in result
   typedef struct packed {
      logic [11:0]      total;
      logic [11:0]      refv;
      logic [11:0]      unk;
      logic             has_fixed;
      meter_result_type fixed;
   } meter_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [11:0] req_total_mv = '0, req_reference_mv = '0, req_unknown_mv = '0;
   logic rsp_strobe, rsp_no_signal;
   logic [tvi_pkg::MAG_OUT_W-1:0] rsp_impedance_magnitude;
   logic signed [tvi_pkg::COS_OUT_W-1:0] rsp_phase_cosine;
   logic signed [tvi_pkg::RES_OUT_W-1:0] rsp_resistive_part;
   logic csr_we = 1'b0;
   logic [tvi_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [tvi_pkg::CSR_W-1:0] csr_wdata = '0;

   three_voltmeter_impedance uut (
      .clock, .reset, .start, .busy,
      .req_total_mv, .req_reference_mv, .req_unknown_mv,
      .rsp_strobe, .rsp_no_signal, .rsp_impedance_magnitude,
      .rsp_phase_cosine, .rsp_resistive_part,
      .csr_we, .csr_index, .csr_wdata
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // local copy of the two registers
   logic [19:0] ohms_sixteenths;
   logic [11:0] floor_mv;

   meter_result_type pending_results[$];
   int  errors = 0;
   int  cycles = 0;
   int  send_idle_pct = 0;

   // impedance prediction from one reading set
   function automatic meter_result_type measure_impedance(logic [11:0] t, logic [11:0] r,
                                                          logic [11:0] x);
      meter_result_type res;
      logic [63:0] mag, pos, neg, den, cmag, rmag;
      logic        cneg;
      res = '0;
      if (t < floor_mv || r < floor_mv || x < floor_mv || r == 0 || x == 0) begin
         res.no_signal = 1'b1;
         return res;
      end
      mag = (64'(ohms_sixteenths) * x) / r;
      if (mag > 64'hFFFF_FFFF) mag = 64'hFFFF_FFFF;
      pos = 64'(t) * t;
      neg = 64'(r) * r + 64'(x) * x;
      den = 2 * 64'(r) * x;
      cneg = pos < neg;
      cmag = cneg ? neg - pos : pos - neg;
      if (cmag >= den) begin
         cmag = cneg ? 64'd32768 : 64'd32767;
      end else begin
         cmag = (cmag << 15) / den;
         if (!cneg && cmag > 32767) cmag = 32767;
      end
      rmag = (mag * cmag) >> 15;
      res.magnitude = mag[31:0];
      res.cosine    = cneg ? 16'(-cmag) : cmag[15:0];
      res.resistive = cneg ? 33'(-rmag) : rmag[32:0];
      return res;
   endfunction

   // cycle limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_MAX) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // result checker: every strobe must match the oldest expectation
   always @(posedge clock) begin
      meter_result_type got, want;
      if (!reset && rsp_strobe) begin
         got = {rsp_no_signal, rsp_impedance_magnitude, rsp_phase_cosine, rsp_resistive_part};
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result %p", $time, got);
            errors++;
         end else begin
            want = pending_results.pop_front();
            if (got.no_signal !== want.no_signal) begin
               $display("%0t: no_signal exp %0d got %0d", $time, want.no_signal, got.no_signal);
               errors++;
            end
            if (got.magnitude !== want.magnitude) begin
               $display("%0t: magnitude exp %0d got %0d", $time, want.magnitude, got.magnitude);
               errors++;
            end
            if (got.cosine !== want.cosine) begin
               $display("%0t: cosine exp %0d got %0d", $time, want.cosine, got.cosine);
               errors++;
            end
            if (got.resistive !== want.resistive) begin
               $display("%0t: resistive exp %0d got %0d", $time, want.resistive,
                        got.resistive);
               errors++;
            end
         end
      end
   end

   // register write at the falling edge, held for one cycle, then csr_we is dropped before returning
   task automatic write_register(logic [tvi_pkg::CSR_IDX_W-1:0] idx,
                                 logic [tvi_pkg::CSR_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == tvi_pkg::CSR_REFERENCE_RESISTANCE) ohms_sixteenths = value[19:0];
      else floor_mv = value[11:0];
      @(negedge clock);
   endtask

   // one reading transfer; fixed result used where the row gives one
   task automatic send_readings(logic [11:0] t, logic [11:0] r, logic [11:0] x,
                                logic has_fixed, meter_result_type fixed);
      while ($urandom_range(99) < send_idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start            <= 1'b1;
      req_total_mv     <= t;
      req_reference_mv <= r;
      req_unknown_mv   <= x;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_results.push_back(has_fixed ? fixed : measure_impedance(t, r, x));
      @(negedge clock);
   endtask

   // wait for every result, then let the pipe empty before a register write
   task automatic drain;
      start <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (LATENCY + 4) @(negedge clock);
   endtask

   // mostly in-range readings, some near or under threshold, some full noise
   task automatic random_readings(int count);
      logic [11:0] t, r, x;
      int kind;
      for (int i = 0; i < count; i++) begin
         kind = $urandom_range(9);
         if (kind == 0) begin
            t = 12'($urandom); r = 12'($urandom); x = 12'($urandom);
         end else if (kind == 1) begin
            t = 12'($urandom_range(20));
            r = 12'($urandom_range(20));
            x = 12'($urandom_range(20));
         end else begin
            // triangle-ish: total between the difference and the sum of the two parts
            r = 12'($urandom_range(4095, 1));
            x = 12'($urandom_range(4095, 1));
            t = 12'($urandom_range((r + x > 4095) ? 4095 : r + x,
                                   (r > x) ? r - x : x - r));
         end
         send_readings(t, r, x, 1'b0, '0);
      end
   endtask

   localparam meter_result_type NOSIG = '{no_signal: 1'b1, default: '0};
   localparam int NROWS = 16;
   meter_row_type rows[NROWS];

   initial begin
      ohms_sixteenths = 20'd1600;
      floor_mv        = 12'd10;
      // directed table: fixed results for the no-signal and at-a-glance rows
      rows[0]  = '{12'd0,    12'd0,    12'd0,    1'b1, NOSIG};
      rows[1]  = '{12'd9,    12'd100,  12'd100,  1'b1, NOSIG};   // total under threshold
      rows[2]  = '{12'd100,  12'd9,    12'd100,  1'b1, NOSIG};
      rows[3]  = '{12'd100,  12'd100,  12'd9,    1'b1, NOSIG};
      rows[4]  = '{12'd10,   12'd10,   12'd10,   1'b0, '0};      // exactly at threshold
      // in phase: t = r + x, cosine clamps high
      rows[5]  = '{12'd200,  12'd100,  12'd100,
                   1'b1, '{1'b0, 32'd1600, 16'sd32767, 33'sd1599}};
      // opposite: t = |r - x|, cosine clamps low
      rows[6]  = '{12'd100,  12'd100,  12'd200,
                   1'b1, '{1'b0, 32'd3200, -16'sd32768, -33'sd3200}};
      rows[7]  = '{12'd4095, 12'd4095, 12'd4095, 1'b0, '0};
      rows[8]  = '{12'd4095, 12'd10,   12'd4095, 1'b0, '0};
      rows[9]  = '{12'd4095, 12'd4095, 12'd10,   1'b0, '0};
      rows[10] = '{12'd141,  12'd100,  12'd100,  1'b0, '0};      // near quadrature
      rows[11] = '{12'd2730, 12'd1365, 12'd2730, 1'b0, '0};
      rows[12] = '{12'd10,   12'd4095, 12'd4095, 1'b0, '0};      // large negative cosine
      rows[13] = '{12'd5,    12'd5,    12'd5,    1'b1, NOSIG};
      rows[14] = '{12'd1365, 12'd2730, 12'd1365, 1'b0, '0};
      rows[15] = '{12'd4095, 12'd2048, 12'd2047, 1'b0, '0};

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (rows[i]) send_readings(rows[i].total, rows[i].refv, rows[i].unk,
                                      rows[i].has_fixed, rows[i].fixed);
      drain();

      // extremes of both registers, and zero threshold (zero reference or unknown still no signal)
      write_register(tvi_pkg::CSR_REFERENCE_RESISTANCE, 20'hFFFFF);
      write_register(tvi_pkg::CSR_MIN_SIGNAL_MV, 20'd0);
      send_readings(12'd4095, 12'd1, 12'd4095, 1'b0, '0);
      send_readings(12'd0, 12'd0, 12'd5, 1'b1, NOSIG);
      send_readings(12'd5, 12'd5, 12'd0, 1'b1, NOSIG);
      send_readings(12'd0, 12'd7, 12'd7, 1'b0, '0);
      drain();
      write_register(tvi_pkg::CSR_REFERENCE_RESISTANCE, 20'd1);
      write_register(tvi_pkg::CSR_MIN_SIGNAL_MV, 20'hFFF);
      send_readings(12'd4095, 12'd4095, 12'd4095, 1'b0, '0);
      send_readings(12'd4094, 12'd4095, 12'd4095, 1'b1, NOSIG);
      drain();

      // random phases with varied registers and sender idle profiles
      for (int p = 0; p < 6; p++) begin
         write_register(tvi_pkg::CSR_REFERENCE_RESISTANCE,
                        (p == 5) ? 20'hFFFFF : 20'($urandom_range(20'hFFFFF, 1)));
         write_register(tvi_pkg::CSR_MIN_SIGNAL_MV,
                        (p == 4) ? 20'd0 : 20'($urandom_range(40)));
         send_idle_pct = (p < 2) ? 11 : (p < 4) ? 61 : 0;
         random_readings(240);
         drain();
      end

      if (errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule

>>> files.f
hw/rtl/tvi_pkg.sv
hw/rtl/tvi_front.sv
hw/rtl/tvi_queue.sv
hw/rtl/tvi_div.sv
hw/rtl/tvi_back.sv
hw/rtl/three_voltmeter_impedance.sv
bench/three_voltmeter_impedance_tb.sv
